// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SLBM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define SLBM_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/slbm_pkg.sv =====
// Types and constants of the serial-loaded bank mapper.
package slbm_pkg;

    localparam int OFF_W = 18;

    // Access opcodes
    localparam logic [1:0] OP_CPU_RD = 2'd0;
    localparam logic [1:0] OP_CPU_WR = 2'd1;
    localparam logic [1:0] OP_VID_RD = 2'd2;
    localparam logic [1:0] OP_VID_WR = 2'd3;

    // Result targets
    localparam logic [1:0] TGT_OPEN  = 2'd0;
    localparam logic [1:0] TGT_PRG   = 2'd1;
    localparam logic [1:0] TGT_SRAM  = 2'd2;
    localparam logic [1:0] TGT_VIDEO = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_PRG_BANKS = 2'd0;
    localparam logic [1:0] REG_CHR_BANKS = 2'd1;
    localparam logic [1:0] REG_HAS_SRAM  = 2'd2;
    localparam logic [1:0] REG_VIDEO_RAM = 2'd3;

    // Program modes from control bits [3:2]
    localparam logic [1:0] PMODE_FIX_LOW  = 2'd2;
    localparam logic [1:0] PMODE_FIX_HIGH = 2'd3;

    localparam logic [4:0] SHIFT_RESET = 5'h10;
    localparam logic [4:0] CTRL_RESET  = 5'h0C;
    localparam logic [2:0] SHIFT_LOAD  = 3'd5;

    localparam logic [4:0] PRG_BANKS_RST = 5'd2;
    localparam logic [5:0] CHR_BANKS_RST = 6'd2;

    typedef struct packed {
        logic [4:0] prg_banks;
        logic [5:0] chr_banks;
        logic       has_sram;
        logic       video_ram;
    } t_cfg;

    typedef struct packed {
        logic [4:0] control;
        logic [4:0] vbank_low;
        logic [4:0] vbank_high;
        logic [3:0] prg_bank;
        logic       sram_en;
    } t_map_state;

endpackage

// ===== hw/rtl/slbm_if.sv =====
// Valid/ready channels for bus accesses and mapping results.
interface slbm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic [31:0] cpu_cycle;

    modport source (output valid, opcode, bus_address, write_data, cpu_cycle, input ready);
    modport sink   (input valid, opcode, bus_address, write_data, cpu_cycle, output ready);
endinterface

interface slbm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  target;
    logic [17:0] mem_offset;
    logic        write_strobe;
    logic [1:0]  mirroring;

    modport source (output valid, target, mem_offset, write_strobe, mirroring, input ready);
    modport sink   (input valid, target, mem_offset, write_strobe, mirroring, output ready);
endinterface

// ===== hw/rtl/slbm_cfg.sv =====
// APB configuration registers of the mapper.
module slbm_cfg
    import slbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prg_banks <= PRG_BANKS_RST;
            r_cfg.chr_banks <= CHR_BANKS_RST;
            r_cfg.has_sram  <= 1'b1;
            r_cfg.video_ram <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_PRG_BANKS: r_cfg.prg_banks <= pwdata[4:0];
                REG_CHR_BANKS: r_cfg.chr_banks <= pwdata[5:0];
                REG_HAS_SRAM:  r_cfg.has_sram  <= pwdata[0];
                REG_VIDEO_RAM: r_cfg.video_ram <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PRG_BANKS: prdata = {27'd0, r_cfg.prg_banks};
            REG_CHR_BANKS: prdata = {26'd0, r_cfg.chr_banks};
            REG_HAS_SRAM:  prdata = {31'd0, r_cfg.has_sram};
            REG_VIDEO_RAM: prdata = {31'd0, r_cfg.video_ram};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

// ===== hw/rtl/slbm_regs.sv =====
// Serial loader and bank registers, with the back-to-back write filter.
`include "assert_macros.svh"
module slbm_regs
    import slbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_proc,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_data,
    input  logic [31:0] i_cycle,
    output t_map_state  o_state,
    output logic [1:0]  o_mirroring
);

    logic [4:0]  r_shift_bits,  n_shift_bits;
    logic [2:0]  r_shift_writes, n_shift_writes;
    logic [31:0] r_last_time,   n_last_time;
    t_map_state  r_state,       n_state;

    logic        w_regwr;
    logic        w_skip;
    logic [2:0]  w_inc;
    logic [4:0]  w_shift;

    assign w_regwr = i_proc && (i_opcode == OP_CPU_WR) && i_addr[15];
    assign w_skip  = (i_cycle == r_last_time + 32'd1) && (r_last_time != 32'd0);
    assign w_inc   = r_shift_writes + 3'd1;
    assign w_shift = {i_data[0], r_shift_bits[4:1]};

    always_comb begin
        n_shift_bits   = r_shift_bits;
        n_shift_writes = r_shift_writes;
        n_last_time    = r_last_time;
        n_state        = r_state;
        if (w_regwr) begin
            n_last_time = i_cycle;
            if (!w_skip) begin
                if (i_data[7]) begin
                    // reset the loader and force program mode 3
                    n_shift_bits   = SHIFT_RESET;
                    n_shift_writes = 3'd0;
                    n_state.control = r_state.control | CTRL_RESET;
                end else if (w_inc < SHIFT_LOAD) begin
                    n_shift_bits   = w_shift;
                    n_shift_writes = w_inc;
                end else begin
                    // fifth bit: load the register picked by address quarter
                    case (i_addr[14:13])
                        2'd0: n_state.control    = w_shift;
                        2'd1: n_state.vbank_low  = w_shift;
                        2'd2: n_state.vbank_high = w_shift;
                        default: begin
                            n_state.prg_bank = w_shift[3:0];
                            n_state.sram_en  = !w_shift[4];
                        end
                    endcase
                    n_shift_bits   = SHIFT_RESET;
                    n_shift_writes = 3'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_bits       <= SHIFT_RESET;
            r_shift_writes     <= 3'd0;
            r_last_time        <= 32'd0;
            r_state.control    <= CTRL_RESET;
            r_state.vbank_low  <= 5'd0;
            r_state.vbank_high <= 5'd0;
            r_state.prg_bank   <= 4'd0;
            r_state.sram_en    <= 1'b1;
        end else begin
            r_shift_bits   <= n_shift_bits;
            r_shift_writes <= n_shift_writes;
            r_last_time    <= n_last_time;
            r_state        <= n_state;
        end
    end

    assign o_state     = r_state;
    assign o_mirroring = n_state.control[1:0];

    `SLBM_ASSERT(a_shift_count, r_shift_writes < SHIFT_LOAD, "shift count past five")
    `SLBM_ASSERT_NXT(a_shift_load,
        w_regwr && !w_skip && !i_data[7] && (r_shift_writes == SHIFT_LOAD - 3'd1),
        (r_shift_writes == 3'd0) && (r_shift_bits == SHIFT_RESET),
        "shift register not cleared after load")

endmodule

// ===== hw/rtl/slbm_xlate.sv =====
// Address decode and bank translation for one access.
module slbm_xlate
    import slbm_pkg::*;
#(
    parameter int PRG_OFFSET_BITS = 18,
    parameter int CHR_OFFSET_BITS = 17
) (
    input  logic [1:0]       i_opcode,
    input  logic [15:0]      i_addr,
    input  t_map_state       i_state,
    input  t_cfg             i_cfg,
    output logic [1:0]       o_target,
    output logic [OFF_W-1:0] o_offset,
    output logic             o_strobe
);

    localparam int CHR_W = OFF_W - 1;
    localparam logic [OFF_W-1:0] PRG_MASK = OFF_W'((1 << PRG_OFFSET_BITS) - 1);
    localparam logic [CHR_W-1:0] CHR_MASK = CHR_W'((1 << CHR_OFFSET_BITS) - 1);

    // program ROM
    logic [2:0]       w_b32;
    logic [3:0]       w_psel;
    logic [3:0]       w_plast;
    logic [OFF_W-1:0] w_lo14;
    logic [OFF_W-1:0] w_prg_raw;
    logic [OFF_W-1:0] w_prg_size;
    logic [OFF_W-1:0] w_prg_off;
    logic [1:0]       w_pmode;

    assign w_pmode    = i_state.control[3:2];
    assign w_b32      = i_state.prg_bank[3:1] & (i_cfg.prg_banks[3:1] - 3'd1);
    assign w_psel     = i_state.prg_bank & (i_cfg.prg_banks[3:0] - 4'd1);
    assign w_plast    = i_cfg.prg_banks[3:0] - 4'd1;
    assign w_lo14     = {4'd0, i_addr[13:0]};
    assign w_prg_size = {i_cfg.prg_banks[3:0], 14'd0} - 18'd1;

    always_comb begin
        case (w_pmode)
            PMODE_FIX_LOW:
                w_prg_raw = i_addr[14] ? ({w_psel, 14'd0} + w_lo14) : {3'd0, i_addr[14:0]};
            PMODE_FIX_HIGH:
                w_prg_raw = i_addr[14] ? ({w_plast, 14'd0} + w_lo14)
                                       : ({w_psel, 14'd0} + w_lo14);
            default:
                w_prg_raw = {w_b32, 15'd0} + {3'd0, i_addr[14:0]};
        endcase
    end

    assign w_prg_off = w_prg_raw & w_prg_size & PRG_MASK;

    // video memory
    logic [3:0]       w_b8;
    logic [4:0]       w_vlo;
    logic [4:0]       w_vhi;
    logic [CHR_W-1:0] w_chr_raw;
    logic [CHR_W-1:0] w_chr_size;
    logic [CHR_W-1:0] w_chr_off;

    assign w_b8       = i_state.vbank_low[4:1] & (i_cfg.chr_banks[4:1] - 4'd1);
    assign w_vlo      = i_state.vbank_low & (i_cfg.chr_banks[4:0] - 5'd1);
    assign w_vhi      = i_state.vbank_high & (i_cfg.chr_banks[4:0] - 5'd1);
    assign w_chr_size = {i_cfg.chr_banks[4:0], 12'd0} - 17'd1;

    always_comb begin
        if (!i_state.control[4]) begin
            w_chr_raw = {w_b8, 13'd0} + {4'd0, i_addr[12:0]};
        end else if (!i_addr[12]) begin
            w_chr_raw = {w_vlo, 12'd0} + {5'd0, i_addr[11:0]};
        end else begin
            w_chr_raw = {w_vhi, 12'd0} + {5'd0, i_addr[11:0]};
        end
    end

    assign w_chr_off = w_chr_raw & w_chr_size & CHR_MASK;

    always_comb begin
        o_target = TGT_OPEN;
        o_offset = '0;
        o_strobe = 1'b0;
        case (i_opcode)
            OP_CPU_RD, OP_CPU_WR: begin
                if (i_addr[15:13] == 3'b011) begin
                    if (i_cfg.has_sram && i_state.sram_en) begin
                        o_target = TGT_SRAM;
                        o_offset = {5'd0, i_addr[12:0]};
                        o_strobe = (i_opcode == OP_CPU_WR);
                    end
                end else if (i_addr[15] && (i_opcode == OP_CPU_RD)) begin
                    o_target = TGT_PRG;
                    o_offset = w_prg_off;
                end
            end
            OP_VID_RD, OP_VID_WR: begin
                if (i_addr[15:13] == 3'b000) begin
                    o_target = TGT_VIDEO;
                    o_offset = {1'b0, w_chr_off};
                    o_strobe = (i_opcode == OP_VID_WR) && i_cfg.video_ram;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/serial_loaded_bank_mapper_unit.sv =====
// Serial-loaded bank mapper: top level with input and result registers.
//
// Usage:
//   i_acc carries one bus access per transfer (opcode, bus_address, write_data,
//   cpu_cycle); o_res returns exactly one result per access (target, mem_offset,
//   write_strobe, mirroring), in order.
//   An access goes into the input register on its transfer, is decoded and
//   applied to the bank registers once the output register can advance, and
//   its result sits in the output register from then on, raising o_res.valid.
//   One access per cycle is sustained while o_res is not stalled; the decode
//   between the two registers sets that figure.
//   If o_res is stalled, the output register holds its result and one more
//   access is taken into the input register; i_acc.ready then drops until
//   the output register drains.
//   The APB port sets bank counts, save RAM presence and video RAM; write it
//   only while no access is in flight.
//   Reset (synchronous, active low) empties both registers, restores the
//   power-up bank and control state and the default configuration.
`include "assert_macros.svh"
module serial_loaded_bank_mapper_unit
    import slbm_pkg::*;
#(
    parameter int PRG_OFFSET_BITS = 18,
    parameter int CHR_OFFSET_BITS = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slbm_in_if.sink     i_acc,
    slbm_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg        w_cfg;
    t_map_state  w_state;

    logic        r_in_valid;
    logic [1:0]  r_opcode;
    logic [15:0] r_addr;
    logic [7:0]  r_data;
    logic [31:0] r_cycle;

    logic             r_out_valid;
    logic [1:0]       r_target,  n_target;
    logic [OFF_W-1:0] r_offset,  n_offset;
    logic             r_strobe,  n_strobe;
    logic [1:0]       r_mirror,  n_mirror;

    logic w_adv;
    logic w_proc;

    assign w_adv       = !r_out_valid || o_res.ready;
    assign w_proc      = r_in_valid && w_adv;
    assign i_acc.ready = !r_in_valid || w_adv;

    slbm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    slbm_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_proc      (w_proc),
        .i_opcode    (r_opcode),
        .i_addr      (r_addr),
        .i_data      (r_data),
        .i_cycle     (r_cycle),
        .o_state     (w_state),
        .o_mirroring (n_mirror)
    );

    slbm_xlate #(
        .PRG_OFFSET_BITS (PRG_OFFSET_BITS),
        .CHR_OFFSET_BITS (CHR_OFFSET_BITS)
    ) u_xlate (
        .i_opcode (r_opcode),
        .i_addr   (r_addr),
        .i_state  (w_state),
        .i_cfg    (w_cfg),
        .o_target (n_target),
        .o_offset (n_offset),
        .o_strobe (n_strobe)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_acc.ready) begin
                r_in_valid <= i_acc.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // hold payloads unless a transfer or an advance replaces them
    always_ff @(posedge i_clk) begin
        if (i_acc.valid && i_acc.ready) begin
            r_opcode <= i_acc.opcode;
            r_addr   <= i_acc.bus_address;
            r_data   <= i_acc.write_data;
            r_cycle  <= i_acc.cpu_cycle;
        end
        if (w_proc) begin
            r_target <= n_target;
            r_offset <= n_offset;
            r_strobe <= n_strobe;
            r_mirror <= n_mirror;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.target       = r_target;
    assign o_res.mem_offset   = r_offset;
    assign o_res.write_strobe = r_strobe;
    assign o_res.mirroring    = r_mirror;

    `SLBM_ASSERT(a_strobe_target, !(r_out_valid && r_strobe && (r_target == TGT_OPEN)),
        "write strobe on open bus")
    `SLBM_ASSERT(a_open_offset, !(r_out_valid && (r_target == TGT_OPEN) && (r_offset != '0)),
        "nonzero offset on open bus")
    `SLBM_ASSERT_NXT(a_proc_lands, w_proc, r_out_valid, "processed access lost")

endmodule
